@@ rtl/core/tlacc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlacc_pkg
// Shared types and constants for the ternary lookup-table accumulator.
// ---------------------------------------------------------------------------
package tlacc_pkg;

   // operation codes
   localparam logic [1:0] OP_WRITE = 2'd0;  // write table entry
   localparam logic [1:0] OP_ACC   = 2'd1;  // accumulate into row partial
   localparam logic [1:0] OP_FOLD  = 2'd2;  // fold partial into row total
   localparam logic [1:0] OP_READ  = 2'd3;  // read and clear row total

   // field widths
   localparam int ROW_W    = 8;
   localparam int GROUP_W  = 5;
   localparam int IDX_W    = 4;
   localparam int PART_W   = 16;
   localparam int TOTAL_W  = 32;

   // entries per group table, and mask of the index field
   localparam int          IDX_PER_GROUP = 16;
   localparam logic [3:0]  IDX_MASK      = 4'h0f;

   typedef logic [1:0]                 opcode_type;
   typedef logic [ROW_W-1:0]           row_type;
   typedef logic [GROUP_W-1:0]         group_type;
   typedef logic [IDX_W-1:0]           index_type;
   typedef logic signed [PART_W-1:0]   value_type;
   typedef logic signed [TOTAL_W-1:0]  total_type;

endpackage

@@ rtl/core/tlacc_channels.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlacc channels
// Valid/ready channel interfaces for request items and response items.
// ---------------------------------------------------------------------------
interface tlacc_req_if;
   logic                   valid;
   logic                   ready;
   tlacc_pkg::opcode_type  opcode;
   tlacc_pkg::row_type     row;
   tlacc_pkg::group_type   group;
   tlacc_pkg::index_type   weight_index;
   logic                   negate;
   tlacc_pkg::value_type   table_value;

   modport source (output valid, output opcode, output row, output group,
                   output weight_index, output negate, output table_value,
                   input ready);
   modport sink   (input valid, input opcode, input row, input group,
                   input weight_index, input negate, input table_value,
                   output ready);
endinterface

interface tlacc_rsp_if;
   logic                   valid;
   logic                   ready;
   tlacc_pkg::row_type     out_row;
   tlacc_pkg::total_type   row_sum;

   modport source (output valid, output out_row, output row_sum, input ready);
   modport sink   (input valid, input out_row, input row_sum, output ready);
endinterface

@@ rtl/core/tlacc_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlacc_ram
// Simple dual-port synchronous RAM with a registered read, write-first
// when a read and a write hit the same entry on the same edge.
// ---------------------------------------------------------------------------
module tlacc_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port; a same-edge write to the read entry is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/tlacc_init.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlacc_init
// Post-reset sweep that walks every row address once so the row memories
// can be zeroed.
// ---------------------------------------------------------------------------
module tlacc_init #(
   parameter int ROWS = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   output logic                     busy,
   output logic [$clog2(ROWS)-1:0]  addr
);

   localparam int RW = $clog2(ROWS);

   logic          busy_ff, busy_in;
   logic [RW-1:0] cnt_ff, cnt_in;

   // sweep counter
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (busy_ff) begin
         if (cnt_ff == RW'(ROWS - 1)) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy = busy_ff;
   assign addr = cnt_ff;

endmodule

@@ rtl/core/ternary_lut_accumulator_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ternary_lut_accumulator_unit
// Lookup-table ternary matrix-vector accumulator: group tables, 16-bit row
// partials and 32-bit row totals held in synchronous RAMs.
// ---------------------------------------------------------------------------
// After reset the unit zeroes the partial and total memories (req.ready
// low), then takes one item per cycle while not stalled. Every item reads
// the memories at the edge it transfers and writes back from the execute
// stage, with same-entry reads forwarded inside the RAMs, so back-to-back
// items on one row need no gaps. A read item loads its result into the
// response register from that stage; while the register is full and not
// taken, a following read item waits in the stage and holds req.ready
// low. Table writes with group >= GROUPS, accumulates with row >= ROWS or
// group >= GROUPS, and folds with row >= ROWS are dropped; a read of such
// a row returns zero. Table entries hold no value until written.
// ---------------------------------------------------------------------------
module ternary_lut_accumulator_unit #(
   parameter int ROWS   = 256,
   parameter int GROUPS = 32
) (
   input  logic         clock,
   input  logic         reset,
   tlacc_req_if.sink    req,
   tlacc_rsp_if.source  rsp
);

   localparam int RW = $clog2(ROWS);
   localparam int TW = $clog2(GROUPS * tlacc_pkg::IDX_PER_GROUP);
   localparam int PW = tlacc_pkg::PART_W;
   localparam int SW = tlacc_pkg::TOTAL_W;

   // clearing sweep
   logic          init_busy;
   logic [RW-1:0] init_addr;

   tlacc_init #(.ROWS(ROWS)) u_init (
      .clock (clock),
      .reset (reset),
      .busy  (init_busy),
      .addr  (init_addr)
   );

   // request decode
   logic [31:0]   req_row_wide;
   logic [31:0]   req_grp_wide;
   logic [31:0]   req_tab_wide;
   logic [RW-1:0] req_row_addr;
   logic [TW-1:0] req_tab_addr;
   logic          req_row_ok;
   logic          req_grp_ok;
   logic          accept;
   logic          stall;

   always_comb begin
      req_row_wide = {{(32 - tlacc_pkg::ROW_W){1'b0}}, req.row};
      req_grp_wide = {{(32 - tlacc_pkg::GROUP_W){1'b0}}, req.group};
      req_tab_wide = (req_grp_wide << tlacc_pkg::IDX_W)
                   | {28'b0, req.weight_index & tlacc_pkg::IDX_MASK};
      req_row_addr = req_row_wide[RW-1:0];
      req_tab_addr = req_tab_wide[TW-1:0];
      req_row_ok   = req_row_wide < 32'(ROWS);
      req_grp_ok   = req_grp_wide < 32'(GROUPS);
   end

   assign req.ready = !init_busy && !stall;
   assign accept    = req.valid && req.ready;

   // group table: written at transfer, read at transfer
   logic [PW-1:0] tab_rd;
   logic          tab_we;

   assign tab_we = accept && (req.opcode == tlacc_pkg::OP_WRITE) && req_grp_ok;

   tlacc_ram #(.DEPTH(GROUPS * tlacc_pkg::IDX_PER_GROUP), .WIDTH(PW)) u_tab (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (req_tab_addr),
      .wr_data (req.table_value),
      .rd_en   (accept),
      .rd_addr (req_tab_addr),
      .rd_data (tab_rd)
   );

   // execute stage registers
   logic                  s_valid_ff, s_valid_in;
   tlacc_pkg::opcode_type s_op_ff;
   tlacc_pkg::row_type    s_row_ff;
   logic [RW-1:0]         s_addr_ff;
   logic                  s_row_ok_ff;
   logic                  s_grp_ok_ff;
   logic                  s_neg_ff;

   always_comb begin
      s_valid_in = s_valid_ff;
      if (req.ready) begin
         s_valid_in = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s_op_ff     <= req.opcode;
         s_row_ff    <= req.row;
         s_addr_ff   <= req_row_addr;
         s_row_ok_ff <= req_row_ok;
         s_grp_ok_ff <= req_grp_ok;
         s_neg_ff    <= req.negate;
      end
   end

   // row memories
   logic [PW-1:0] part_rd;
   logic [SW-1:0] tot_rd;
   logic          part_we;
   logic [PW-1:0] part_wdata;
   logic          tot_we;
   logic [SW-1:0] tot_wdata;
   logic          p_we;
   logic [RW-1:0] p_waddr;
   logic [PW-1:0] p_wdata;
   logic          t_we;
   logic [SW-1:0] t_wdata;

   // the sweep owns the write ports until it finishes
   always_comb begin
      if (init_busy) begin
         p_we    = 1'b1;
         t_we    = 1'b1;
         p_waddr = init_addr;
         p_wdata = '0;
         t_wdata = '0;
      end else begin
         p_we    = part_we;
         t_we    = tot_we;
         p_waddr = s_addr_ff;
         p_wdata = part_wdata;
         t_wdata = tot_wdata;
      end
   end

   tlacc_ram #(.DEPTH(ROWS), .WIDTH(PW)) u_part (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_en   (accept),
      .rd_addr (req_row_addr),
      .rd_data (part_rd)
   );

   tlacc_ram #(.DEPTH(ROWS), .WIDTH(SW)) u_tot (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (p_waddr),
      .wr_data (t_wdata),
      .rd_en   (accept),
      .rd_addr (req_row_addr),
      .rd_data (tot_rd)
   );

   // execute: modify and write back
   logic          s_fire;
   logic [PW-1:0] addend;
   logic          rsp_load;

   assign stall  = s_valid_ff && (s_op_ff == tlacc_pkg::OP_READ)
                && rsp.valid && !rsp.ready;
   assign s_fire = s_valid_ff && !stall;

   always_comb begin
      addend     = s_neg_ff ? (PW'(0) - tab_rd) : tab_rd;
      part_we    = 1'b0;
      part_wdata = '0;
      tot_we     = 1'b0;
      tot_wdata  = '0;
      rsp_load   = 1'b0;
      if (s_fire) begin
         unique case (s_op_ff)
            tlacc_pkg::OP_WRITE: begin
               part_we = 1'b0;
            end
            tlacc_pkg::OP_ACC: begin
               part_we    = s_row_ok_ff && s_grp_ok_ff;
               part_wdata = part_rd + addend;
            end
            tlacc_pkg::OP_FOLD: begin
               part_we    = s_row_ok_ff;
               part_wdata = '0;
               tot_we     = s_row_ok_ff;
               tot_wdata  = tot_rd + {{(SW - PW){part_rd[PW-1]}}, part_rd};
            end
            tlacc_pkg::OP_READ: begin
               tot_we    = s_row_ok_ff;
               tot_wdata = '0;
               rsp_load  = 1'b1;
            end
            default: begin
               part_we = 1'b0;
            end
         endcase
      end
   end

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   tlacc_pkg::row_type   rsp_row_ff;
   tlacc_pkg::total_type rsp_sum_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_ff <= s_row_ff;
         rsp_sum_ff <= s_row_ok_ff ? tot_rd : '0;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.out_row = rsp_row_ff;
   assign rsp.row_sum = rsp_sum_ff;

endmodule

@@ bench/ternary_lut_accumulator_unit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ternary_lut_accumulator_unit_test
// Self-checking bench for the ternary lookup-table accumulator. A directed
// sequence covers the field extremes, every opcode, 16-bit partial wrap and
// negation of the most negative table value. It is followed by random
// traffic that is biased toward a few busy rows. Every accepted request
// runs through a behavioral copy of the tables, partials and totals. Each
// read-out transfer is checked against the oldest predicted read-out. Both
// channels idle at random, with one stretch of back-to-back traffic.
// ---------------------------------------------------------------------------
module ternary_lut_accumulator_unit_test;

   localparam int ROWS_CFG     = 256;
   localparam int GROUPS_CFG   = 32;
   localparam int LUT_DEPTH    = GROUPS_CFG * tlacc_pkg::IDX_PER_GROUP;
   localparam int RANDOM_ITEMS = 1630;
   localparam int DRAIN_CYCLES = 8;

   // one request, plus an optional hand-written expected total for reads
   typedef struct packed {
      tlacc_pkg::opcode_type  op;
      tlacc_pkg::row_type     row;
      tlacc_pkg::group_type   grp;
      tlacc_pkg::index_type   idx;
      logic                   neg;
      tlacc_pkg::value_type   value;
      logic                   has_sum;
      tlacc_pkg::total_type   sum;
   } request_type;

   typedef struct packed {
      tlacc_pkg::row_type     row;
      tlacc_pkg::total_type   sum;
   } readout_type;

   logic clock;
   logic reset;
   logic steady;        // no idling on either side while set
   int   fault_count;

   tlacc_req_if req_ch ();
   tlacc_rsp_if rsp_ch ();

   ternary_lut_accumulator_unit #(
      .ROWS   (ROWS_CFG),
      .GROUPS (GROUPS_CFG)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // behavioral copy of the block state
   logic [15:0] lut_mem     [LUT_DEPTH];
   bit          lut_written [LUT_DEPTH];
   int          written_keys [$];
   logic [15:0] partial_mem [ROWS_CFG];
   logic [31:0] total_mem   [ROWS_CFG];
   readout_type pending_readouts [$];

   // directed sequence; typed sums only where they are obvious
   request_type directed_items [24] = '{
      '{tlacc_pkg::OP_READ,  8'd0,   5'd0,  4'd0,  1'b0, 16'h0000, 1'b1, 32'h00000000},
      '{tlacc_pkg::OP_READ,  8'd255, 5'd31, 4'd15, 1'b1, 16'hffff, 1'b1, 32'h00000000},
      '{tlacc_pkg::OP_WRITE, 8'd0,   5'd0,  4'd0,  1'b0, 16'h7fff, 1'b0, 32'h0},
      '{tlacc_pkg::OP_WRITE, 8'd0,   5'd31, 4'd15, 1'b0, 16'h8000, 1'b0, 32'h0},
      '{tlacc_pkg::OP_WRITE, 8'd0,   5'd0,  4'd15, 1'b0, 16'hffff, 1'b0, 32'h0},
      '{tlacc_pkg::OP_WRITE, 8'd0,   5'd31, 4'd0,  1'b0, 16'h0001, 1'b0, 32'h0},
      // 0x7fff + 1 wraps the partial to the most negative value
      '{tlacc_pkg::OP_ACC,   8'd0,   5'd0,  4'd0,  1'b0, 16'h0000, 1'b0, 32'h0},
      '{tlacc_pkg::OP_ACC,   8'd0,   5'd31, 4'd0,  1'b0, 16'h0000, 1'b0, 32'h0},
      '{tlacc_pkg::OP_FOLD,  8'd0,   5'd0,  4'd0,  1'b0, 16'h0000, 1'b0, 32'h0},
      '{tlacc_pkg::OP_READ,  8'd0,   5'd0,  4'd0,  1'b0, 16'h0000, 1'b1, 32'hffff8000},
      '{tlacc_pkg::OP_READ,  8'd0,   5'd0,  4'd0,  1'b0, 16'h0000, 1'b1, 32'h00000000},
      // negated -32768 stays -32768
      '{tlacc_pkg::OP_ACC,   8'd255, 5'd31, 4'd15, 1'b1, 16'h0000, 1'b0, 32'h0},
      '{tlacc_pkg::OP_FOLD,  8'd255, 5'd0,  4'd0,  1'b0, 16'h0000, 1'b0, 32'h0},
      '{tlacc_pkg::OP_READ,  8'd255, 5'd0,  4'd0,  1'b0, 16'h0000, 1'b1, 32'hffff8000},
      '{tlacc_pkg::OP_ACC,   8'd1,   5'd0,  4'd15, 1'b1, 16'h0000, 1'b0, 32'h0},
      '{tlacc_pkg::OP_ACC,   8'd1,   5'd0,  4'd0,  1'b1, 16'h0000, 1'b0, 32'h0},
      '{tlacc_pkg::OP_FOLD,  8'd1,   5'd0,  4'd0,  1'b0, 16'h0000, 1'b0, 32'h0},
      '{tlacc_pkg::OP_FOLD,  8'd1,   5'd0,  4'd0,  1'b0, 16'h0000, 1'b0, 32'h0},
      '{tlacc_pkg::OP_READ,  8'd1,   5'd0,  4'd0,  1'b0, 16'h0000, 1'b0, 32'h0},
      // unused fields carry junk and must be ignored
      '{tlacc_pkg::OP_WRITE, 8'd255, 5'd16, 4'd10, 1'b1, 16'h5a5a, 1'b0, 32'h0},
      '{tlacc_pkg::OP_ACC,   8'd2,   5'd16, 4'd10, 1'b0, 16'ha5a5, 1'b0, 32'h0},
      '{tlacc_pkg::OP_ACC,   8'd2,   5'd16, 4'd10, 1'b0, 16'h0000, 1'b0, 32'h0},
      '{tlacc_pkg::OP_FOLD,  8'd2,   5'd31, 4'd15, 1'b1, 16'hffff, 1'b0, 32'h0},
      '{tlacc_pkg::OP_READ,  8'd2,   5'd21, 4'd5,  1'b1, 16'h8000, 1'b0, 32'h0}
   };

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // apply one accepted request to the copy; returns a read-out for reads
   function automatic void predict_readout(input request_type it, output logic produces,
                                           output readout_type res);
      int          addr;
      logic [15:0] v;
      logic [15:0] part;
      produces = 1'b0;
      res      = '0;
      addr     = int'(it.grp) * tlacc_pkg::IDX_PER_GROUP
               + int'(it.idx & tlacc_pkg::IDX_MASK);
      case (it.op)
         tlacc_pkg::OP_WRITE: begin
            if (int'(it.grp) < GROUPS_CFG) begin
               lut_mem[addr] = it.value;
               if (!lut_written[addr]) begin
                  lut_written[addr] = 1'b1;
                  written_keys.push_back(addr);
               end
            end
         end
         tlacc_pkg::OP_ACC: begin
            if (int'(it.row) < ROWS_CFG && int'(it.grp) < GROUPS_CFG) begin
               v = lut_mem[addr];
               if (it.neg) v = 16'd0 - v;
               partial_mem[it.row] = partial_mem[it.row] + v;
            end
         end
         tlacc_pkg::OP_FOLD: begin
            if (int'(it.row) < ROWS_CFG) begin
               part = partial_mem[it.row];
               total_mem[it.row] = total_mem[it.row] + {{16{part[15]}}, part};
               partial_mem[it.row] = '0;
            end
         end
         tlacc_pkg::OP_READ: begin
            produces = 1'b1;
            res.row  = it.row;
            if (int'(it.row) < ROWS_CFG) begin
               res.sum = total_mem[it.row];
               total_mem[it.row] = '0;
            end
         end
         default: ;
      endcase
   endfunction

   // present one request and hold it until the transfer
   task automatic send_request(input request_type it);
      logic        took;
      logic        produces;
      readout_type res;
      while (!steady && $urandom_range(99) < 13) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= it.op;
      req_ch.row          <= it.row;
      req_ch.group        <= it.grp;
      req_ch.weight_index <= it.idx;
      req_ch.negate       <= it.neg;
      req_ch.table_value  <= it.value;
      took = 1'b0;
      while (!took) begin
         // inputs settle between edges, so sample the handshake mid-cycle
         @(negedge clock);
         took = req_ch.ready;
         if (took) begin
            predict_readout(it, produces, res);
            if (produces) begin
               if (it.has_sum) res.sum = it.sum;
               pending_readouts.push_back(res);
            end
         end
         @(posedge clock);
      end
   endtask

   // random request, mostly on a few hot rows, lookups only on written entries
   function automatic request_type random_request();
      request_type it;
      int          pick;
      int          key;
      it        = '0;
      pick      = $urandom_range(99);
      it.grp    = tlacc_pkg::group_type'($urandom_range(31));
      it.idx    = tlacc_pkg::index_type'($urandom_range(15));
      it.neg    = 1'($urandom_range(1));
      it.value  = tlacc_pkg::value_type'($urandom);
      it.row    = ($urandom_range(99) < 60) ? tlacc_pkg::row_type'($urandom_range(3))
                                            : tlacc_pkg::row_type'($urandom_range(255));
      if (pick < 15 || written_keys.size() == 0) begin
         it.op = tlacc_pkg::OP_WRITE;
         case ($urandom_range(9))
            0: it.value = 16'h8000;
            1: it.value = 16'h7fff;
            2: it.value = 16'hffff;
            3: it.value = 16'h0000;
            default: ;
         endcase
      end else if (pick < 65) begin
         it.op = tlacc_pkg::OP_ACC;
         key = int'(it.grp) * tlacc_pkg::IDX_PER_GROUP + int'(it.idx);
         if (!lut_written[key]) begin
            key    = written_keys[$urandom_range(written_keys.size() - 1)];
            it.grp = tlacc_pkg::group_type'(key / tlacc_pkg::IDX_PER_GROUP);
            it.idx = tlacc_pkg::index_type'(key % tlacc_pkg::IDX_PER_GROUP);
         end
      end else if (pick < 82) begin
         it.op = tlacc_pkg::OP_FOLD;
      end else begin
         it.op = tlacc_pkg::OP_READ;
      end
      return it;
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(99) >= 13);
      end
   end

   // read-out checker; a transfer lands at the next rising edge
   always @(negedge clock) begin
      readout_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_readouts.size() == 0) begin
            $error("unexpected read-out: out_row %0d row_sum %0d",
                   rsp_ch.out_row, rsp_ch.row_sum);
            fault_count++;
         end else begin
            want = pending_readouts.pop_front();
            if (rsp_ch.out_row !== want.row) begin
               $error("out_row mismatch: expected %0d, actual %0d", want.row, rsp_ch.out_row);
               fault_count++;
            end
            if (rsp_ch.row_sum !== want.sum) begin
               $error("row_sum mismatch: expected %0d, actual %0d",
                      $signed(want.sum), $signed(rsp_ch.row_sum));
               fault_count++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      reset               = 1'b1;
      steady              = 1'b0;
      fault_count         = 0;
      req_ch.valid        = 1'b0;
      req_ch.opcode       = tlacc_pkg::OP_WRITE;
      req_ch.row          = '0;
      req_ch.group        = '0;
      req_ch.weight_index = '0;
      req_ch.negate       = 1'b0;
      req_ch.table_value  = '0;
      for (int i = 0; i < LUT_DEPTH; i++) begin
         lut_mem[i]     = '0;
         lut_written[i] = 1'b0;
      end
      for (int i = 0; i < ROWS_CFG; i++) begin
         partial_mem[i] = '0;
         total_mem[i]   = '0;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_items[i]) send_request(directed_items[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady <= (n >= 700 && n < 1000);
         send_request(random_request());
      end
      req_ch.valid <= 1'b0;
      steady       <= 1'b0;

      // let outstanding read-outs arrive, then watch for strays
      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("ternary_lut_accumulator_unit test passed");
      end else begin
         $display("ternary_lut_accumulator_unit test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("ternary_lut_accumulator_unit test failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/tlacc_pkg.sv
rtl/core/tlacc_channels.sv
rtl/core/tlacc_ram.sv
rtl/core/tlacc_init.sv
rtl/core/ternary_lut_accumulator_unit.sv
bench/ternary_lut_accumulator_unit_test.sv
